### rtl/memory_request_queue_with_forwarding_unit_defines.svh
// Assertion macros shared by the request queue checker
`ifndef MEMORY_REQUEST_QUEUE_WITH_FORWARDING_UNIT_DEFINES_SVH
`define MEMORY_REQUEST_QUEUE_WITH_FORWARDING_UNIT_DEFINES_SVH

// clocked property, switched off while reset is low
`define MRQF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property that applies only while a result is on show
`define MRQF_ASSERT_VALID(label, clk, rst_n, vld, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (vld) |-> (prop)) \
        else $error(msg);

`endif

### rtl/mrqf_pkg.sv
// Types, codes and constants of the memory request queue
package mrqf_pkg;

    localparam int DEF_CHANNELS          = 2;
    localparam int DEF_READ_QUEUE_DEPTH  = 32;
    localparam int DEF_WRITE_QUEUE_DEPTH = 32;

    localparam int ADDRESS_BITS = 40;
    localparam int CORE_COUNT   = 4;
    localparam int DATA_W       = 64;
    localparam int CPU_W        = 2;
    localparam int SLOT_W       = 5;
    localparam int OCC_W        = 6;
    localparam int ROUTE_BITS   = 3;
    localparam int FIFO_DEPTH   = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    // word index of each register (byte address bits above the word offset)
    localparam logic [CFG_ADDR_W-3:0] REG_WARMUP_DONE = '0;

    typedef enum logic [0:0] {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_MERGED    = 3'd1,
        ST_FORWARDED = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_BYPASS    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        K_BYPASS,
        K_DROP,
        K_READ,
        K_WRITE
    } t_kind;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_RESOLVE,
        BS_FWD
    } t_back_state;

    typedef struct packed {
        t_cmd                    command;
        logic [ADDRESS_BITS-1:0] address;
        logic [DATA_W-1:0]       write_data;
        logic [CPU_W-1:0]        requester_cpu;
        logic                    is_instruction;
        logic                    is_data_access;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic              channel;
        logic [SLOT_W-1:0] slot_index;
        logic              route_to_nvm;
        logic              reply_to_icache;
        logic              reply_to_dcache;
        logic [CPU_W-1:0]  reply_cpu;
        logic [DATA_W-1:0] reply_data;
        logic [OCC_W-1:0]  read_occupancy;
        logic [OCC_W-1:0]  write_occupancy;
    } t_rsp;

    // classified request handed from the front end to the back end
    typedef struct packed {
        t_kind                   kind;
        logic [ADDRESS_BITS-1:0] address;
        logic [DATA_W-1:0]       write_data;
        logic                    route_to_nvm;
        logic                    bypass_reply;
        logic                    icache_ok;
        logic                    dcache_ok;
        logic [CPU_W-1:0]        reply_cpu;
    } t_item;

endpackage

### rtl/mrqf_ram.sv
// Generic single-write, single-read RAM with registered read data
module mrqf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/mrqf_fifo.sv
// Small register FIFO used for the request and result queues
module mrqf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

### rtl/mrqf_front.sv
// Front end: classifies incoming requests and queues them for the back end
module mrqf_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_warmup_done,
    input  logic            i_push,
    input  mrqf_pkg::t_req  i_req,
    output logic            o_full,
    input  logic            i_take,
    output logic            o_item_valid,
    output mrqf_pkg::t_item o_item
);
    import mrqf_pkg::*;

    t_item                     item_c;
    logic                      cpu_ok;
    logic                      empty;
    logic [$bits(t_item)-1:0]  item_raw;

    always_comb begin
        cpu_ok = int'(i_req.requester_cpu) < CORE_COUNT;

        item_c.address      = i_req.address;
        item_c.write_data   = i_req.write_data;
        item_c.route_to_nvm = |i_req.address[ADDRESS_BITS-1 -: ROUTE_BITS];
        item_c.bypass_reply = !i_warmup_done && (i_req.command == CMD_READ);
        item_c.icache_ok    = cpu_ok && i_req.is_instruction;
        item_c.dcache_ok    = cpu_ok && i_req.is_data_access;
        item_c.reply_cpu    = (cpu_ok && (i_req.is_instruction || i_req.is_data_access))
                              ? i_req.requester_cpu : '0;

        if (!i_warmup_done) begin
            item_c.kind = K_BYPASS;
        end else if (i_req.address == '0) begin
            item_c.kind = K_DROP;
        end else if (i_req.command == CMD_READ) begin
            item_c.kind = K_READ;
        end else begin
            item_c.kind = K_WRITE;
        end
    end

    mrqf_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (FIFO_DEPTH)
    ) u_req_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (item_c),
        .i_pop   (i_take),
        .o_full  (o_full),
        .o_empty (empty),
        .o_data  (item_raw)
    );

    assign o_item_valid = !empty;
    assign o_item       = t_item'(item_raw);

endmodule

### rtl/mrqf_back.sv
// Back end: address match, slot pick, queue update and write data store
module mrqf_back #(
    parameter int CHANNELS          = mrqf_pkg::DEF_CHANNELS,
    parameter int READ_QUEUE_DEPTH  = mrqf_pkg::DEF_READ_QUEUE_DEPTH,
    parameter int WRITE_QUEUE_DEPTH = mrqf_pkg::DEF_WRITE_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_item_valid,
    input  mrqf_pkg::t_item i_item,
    output logic            o_take,
    input  logic            i_out_full,
    output logic            o_res_valid,
    output mrqf_pkg::t_rsp  o_res
);
    import mrqf_pkg::*;

    localparam int RD        = READ_QUEUE_DEPTH;
    localparam int WD        = WRITE_QUEUE_DEPTH;
    localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int RI_W      = $clog2(RD);
    localparam int WI_W      = $clog2(WD);
    localparam int RC_W      = $clog2(RD + 1);
    localparam int WC_W      = $clog2(WD + 1);
    localparam int RAM_AW    = CH_W + WI_W;
    localparam int RAM_DEPTH = 1 << RAM_AW;

    // queue addresses; an entry is live when its index is below the fill count
    logic [ADDRESS_BITS-1:0] r_rd_addr [CHANNELS][RD];
    logic [ADDRESS_BITS-1:0] r_wr_addr [CHANNELS][WD];
    logic [RC_W-1:0]         r_rd_count [CHANNELS];
    logic [WC_W-1:0]         r_wr_count [CHANNELS];

    t_back_state r_state, n_state;
    t_item       r_item;
    logic [CH_W-1:0] r_ch;
    logic [RD-1:0]   r_rd_hit;
    logic [WD-1:0]   r_wr_hit;
    t_rsp            r_res;

    logic [CH_W-1:0] head_ch;
    logic [RD-1:0]   rd_hit_all [CHANNELS];
    logic [WD-1:0]   wr_hit_all [CHANNELS];

    logic            rd_any, wr_any;
    logic [RI_W-1:0] rd_idx;
    logic [WI_W-1:0] wr_idx;
    logic [RC_W-1:0] cur_rc, n_rc;
    logic [WC_W-1:0] cur_wc, n_wc;
    logic            rd_ins, wr_ins, fwd, reply;
    t_status         status;
    logic [SLOT_W-1:0] slot;
    t_rsp            res_c;
    logic [DATA_W-1:0] ram_rd_data;

    assign head_ch = i_item.address[CH_W-1:0] & CH_W'(CHANNELS - 1);

    // one comparator per stored entry
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            for (int i = 0; i < RD; i++) begin
                rd_hit_all[c][i] = (r_rd_addr[c][i] == i_item.address)
                                   && (RC_W'(i) < r_rd_count[c]);
            end
            for (int i = 0; i < WD; i++) begin
                wr_hit_all[c][i] = (r_wr_addr[c][i] == i_item.address)
                                   && (WC_W'(i) < r_wr_count[c]);
            end
        end
    end

    // lowest matching slot
    always_comb begin
        rd_any = |r_rd_hit;
        wr_any = |r_wr_hit;
        rd_idx = '0;
        wr_idx = '0;
        for (int i = RD - 1; i >= 0; i--) begin
            if (r_rd_hit[i]) begin
                rd_idx = RI_W'(i);
            end
        end
        for (int i = WD - 1; i >= 0; i--) begin
            if (r_wr_hit[i]) begin
                wr_idx = WI_W'(i);
            end
        end
    end

    always_comb begin
        cur_rc = r_rd_count[r_ch];
        cur_wc = r_wr_count[r_ch];
        status = ST_DROPPED;
        slot   = '0;
        rd_ins = 1'b0;
        wr_ins = 1'b0;
        fwd    = 1'b0;
        reply  = 1'b0;
        case (r_item.kind)
            K_BYPASS: begin
                status = ST_BYPASS;
                reply  = r_item.bypass_reply;
            end
            K_READ: begin
                if (wr_any) begin
                    status = ST_FORWARDED;
                    slot   = SLOT_W'(wr_idx);
                    fwd    = 1'b1;
                    reply  = 1'b1;
                end else if (rd_any) begin
                    status = ST_MERGED;
                    slot   = SLOT_W'(rd_idx);
                end else if (cur_rc != RC_W'(RD)) begin
                    status = ST_INSERTED;
                    slot   = SLOT_W'(cur_rc[RI_W-1:0]);
                    rd_ins = 1'b1;
                end
            end
            K_WRITE: begin
                if (wr_any) begin
                    status = ST_MERGED;
                    slot   = SLOT_W'(wr_idx);
                end else if (cur_wc != WC_W'(WD)) begin
                    status = ST_INSERTED;
                    slot   = SLOT_W'(cur_wc[WI_W-1:0]);
                    wr_ins = 1'b1;
                end
            end
            default: begin
                status = ST_DROPPED;
            end
        endcase
        n_rc = cur_rc + RC_W'(rd_ins);
        n_wc = cur_wc + WC_W'(wr_ins);

        res_c.status          = status;
        res_c.channel         = r_ch[0];
        res_c.slot_index      = slot;
        res_c.route_to_nvm    = r_item.route_to_nvm;
        res_c.reply_to_icache = reply && r_item.icache_ok;
        res_c.reply_to_dcache = reply && r_item.dcache_ok;
        res_c.reply_cpu       = reply ? r_item.reply_cpu : '0;
        res_c.reply_data      = '0;
        res_c.read_occupancy  = OCC_W'(n_rc);
        res_c.write_occupancy = OCC_W'(n_wc);
    end

    always_comb begin
        n_state     = r_state;
        o_take      = 1'b0;
        o_res_valid = 1'b0;
        o_res       = res_c;
        case (r_state)
            BS_IDLE: begin
                if (i_item_valid && !i_out_full) begin
                    o_take  = 1'b1;
                    n_state = BS_RESOLVE;
                end
            end
            BS_RESOLVE: begin
                if (fwd) begin
                    n_state = BS_FWD;
                end else begin
                    o_res_valid = 1'b1;
                    n_state     = BS_IDLE;
                end
            end
            BS_FWD: begin
                o_res            = r_res;
                o_res.reply_data = ram_rd_data;
                o_res_valid      = 1'b1;
                n_state          = BS_IDLE;
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_rd_count[c] <= '0;
                r_wr_count[c] <= '0;
            end
        end else if (r_state == BS_RESOLVE) begin
            r_rd_count[r_ch] <= n_rc;
            r_wr_count[r_ch] <= n_wc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_item   <= i_item;
            r_ch     <= head_ch;
            r_rd_hit <= rd_hit_all[head_ch];
            r_wr_hit <= wr_hit_all[head_ch];
        end
        if (r_state == BS_RESOLVE) begin
            r_res <= res_c;
            if (rd_ins) begin
                r_rd_addr[r_ch][cur_rc[RI_W-1:0]] <= r_item.address;
            end
            if (wr_ins) begin
                r_wr_addr[r_ch][cur_wc[WI_W-1:0]] <= r_item.address;
            end
        end
    end

    mrqf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_wdata_ram (
        .i_clk     (i_clk),
        .i_wr_en   ((r_state == BS_RESOLVE) && wr_ins),
        .i_wr_addr ({r_ch, cur_wc[WI_W-1:0]}),
        .i_wr_data (r_item.write_data),
        .i_rd_en   ((r_state == BS_RESOLVE) && fwd),
        .i_rd_addr ({r_ch, wr_idx}),
        .o_rd_data (ram_rd_data)
    );

endmodule

### rtl/memory_request_queue_with_forwarding_unit.sv
// Top level of the memory request queue with write forwarding
//
//  channel   | direction | transfer when            | payload
//  ----------+-----------+--------------------------+---------------------
//  request   | in        | push && !full            | i_req  (t_req)
//  result    | out       | pop && !empty            | o_rsp  (t_rsp)
//  config    | in        | psel&&penable&&pwrite    | pwdata, word at paddr
//
// The back end works on one request at a time: a match register, then slot
// pick and queue update; a forwarded read adds a step for the data RAM's
// registered read. Reset clears fill counts, warmup and both FIFOs at once.
// full rises when the two-entry request FIFO fills; the back end waits
// while the two-entry result FIFO is full.
module memory_request_queue_with_forwarding_unit #(
    parameter int CHANNELS          = mrqf_pkg::DEF_CHANNELS,
    parameter int READ_QUEUE_DEPTH  = mrqf_pkg::DEF_READ_QUEUE_DEPTH,
    parameter int WRITE_QUEUE_DEPTH = mrqf_pkg::DEF_WRITE_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mrqf_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [mrqf_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [mrqf_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              push,
    input  mrqf_pkg::t_req                    i_req,
    output logic                              full,
    output logic                              empty,
    input  logic                              pop,
    output mrqf_pkg::t_rsp                    o_rsp
);
    import mrqf_pkg::*;

    logic                     r_warmup_done;
    logic                     warm_sel;
    logic                     item_valid;
    t_item                    item;
    logic                     take;
    logic                     res_valid;
    t_rsp                     res;
    logic                     out_full;
    logic [$bits(t_rsp)-1:0]  rsp_raw;

    assign pready   = 1'b1;
    assign warm_sel = (paddr[CFG_ADDR_W-1:2] == REG_WARMUP_DONE);
    assign prdata   = warm_sel ? CFG_DATA_W'(r_warmup_done) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warmup_done <= 1'b0;
        end else if (psel && penable && pwrite && pready && warm_sel) begin
            r_warmup_done <= pwdata[0];
        end
    end

    mrqf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_warmup_done (r_warmup_done),
        .i_push        (push),
        .i_req         (i_req),
        .o_full        (full),
        .i_take        (take),
        .o_item_valid  (item_valid),
        .o_item        (item)
    );

    mrqf_back #(
        .CHANNELS          (CHANNELS),
        .READ_QUEUE_DEPTH  (READ_QUEUE_DEPTH),
        .WRITE_QUEUE_DEPTH (WRITE_QUEUE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_take       (take),
        .i_out_full   (out_full),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    mrqf_fifo #(
        .WIDTH ($bits(t_rsp)),
        .DEPTH (FIFO_DEPTH)
    ) u_rsp_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (pop),
        .o_full  (out_full),
        .o_empty (empty),
        .o_data  (rsp_raw)
    );

    assign o_rsp = t_rsp'(rsp_raw);

endmodule

### rtl/mrqf_checker.sv
// Port-level checks on the request queue, bound to the top level
`include "memory_request_queue_with_forwarding_unit_defines.svh"

module mrqf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input mrqf_pkg::t_rsp o_rsp
);
    import mrqf_pkg::*;

    logic drained;
    logic data_ok;
    logic reply_ok;
    logic waiting;

    assign drained  = empty && !full;
    assign data_ok  = (o_rsp.status == ST_FORWARDED) || (o_rsp.reply_data == '0);
    assign reply_ok = (!o_rsp.reply_to_icache && !o_rsp.reply_to_dcache)
                      || (o_rsp.status == ST_FORWARDED) || (o_rsp.status == ST_BYPASS);
    assign waiting  = !empty && !pop;

    // both queues come out of reset drained
    `MRQF_ASSERT(a_reset_idle, i_clk, i_rst_n, $rose(i_rst_n) |-> drained, "busy after reset")

    // only a forwarded read carries data
    `MRQF_ASSERT_VALID(a_data_only_fwd, i_clk, i_rst_n, !empty, data_ok, "stray reply data")

    // immediate replies come only from bypass or forwarding
    `MRQF_ASSERT_VALID(a_reply_source, i_clk, i_rst_n, !empty, reply_ok, "stray reply")

    `MRQF_ASSERT(a_rsp_hold, i_clk, i_rst_n, waiting |=> !empty && $stable(o_rsp), "result moved")

endmodule

bind memory_request_queue_with_forwarding_unit mrqf_checker u_mrqf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_rsp   (o_rsp)
);

### verif/tb.sv
// Self-checking testbench for the memory request queue with write forwarding
`timescale 1ns / 1ps

module tb;
    import mrqf_pkg::*;

    localparam int CHANNELS     = DEF_CHANNELS;
    localparam int RQ_DEPTH     = DEF_READ_QUEUE_DEPTH;
    localparam int WQ_DEPTH     = DEF_WRITE_QUEUE_DEPTH;
    localparam int POOL_SIZE    = 48;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 300;

    logic                    i_clk   = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    psel    = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0]   paddr   = '0;
    logic [CFG_DATA_W-1:0]   pwdata  = '0;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;
    logic                    push    = 1'b0;
    t_req                    i_req   = '0;
    logic                    full;
    logic                    empty;
    logic                    pop     = 1'b0;
    t_rsp                    o_rsp;

    memory_request_queue_with_forwarding_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .push    (push),
        .i_req   (i_req),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .o_rsp   (o_rsp)
    );

    always #6 i_clk = ~i_clk;

    // shadow copy of the queue state
    logic [ADDRESS_BITS-1:0] rq_addr [CHANNELS][RQ_DEPTH];
    logic [ADDRESS_BITS-1:0] wq_addr [CHANNELS][WQ_DEPTH];
    logic [DATA_W-1:0]       wq_data [CHANNELS][WQ_DEPTH];
    logic [OCC_W-1:0]        rd_cnt  [CHANNELS];
    logic [OCC_W-1:0]        wr_cnt  [CHANNELS];
    logic                    warm_model = 1'b0;

    logic [ADDRESS_BITS-1:0] addr_pool [POOL_SIZE];

    t_req pending_reqs [$];
    t_rsp expected_rsp [$];

    int  queued_cnt   = 0;
    int  accepted_cnt = 0;
    int  rsp_count    = 0;
    int  err_count    = 0;
    int  idle_cycles  = 0;
    int  gap_left     = 0;
    int  burst_left   = 0;
    int  hold_cnt     = 0;
    int  run_cnt      = 0;
    bit  req_taken    = 1'b0;
    bit  long_hold_done = 1'b0;

    function automatic t_rsp predict_request(input t_req r);
        t_rsp p;
        int   ch;
        int   hit;
        int   slot;
        logic reply;
        p = '0;
        p.status = ST_DROPPED;
        ch = int'(r.address & (CHANNELS - 1));
        slot = 0;
        reply = 1'b0;
        if (!warm_model) begin
            p.status = ST_BYPASS;
            reply = (r.command == CMD_READ);
        end else if (r.address != '0) begin
            hit = -1;
            for (int i = WQ_DEPTH - 1; i >= 0; i--)
                if (wq_addr[ch][i] == r.address) hit = i;
            if (r.command == CMD_READ && hit >= 0) begin
                p.status = ST_FORWARDED;
                slot = hit;
                p.reply_data = wq_data[ch][hit];
                reply = 1'b1;
            end else if (r.command == CMD_READ) begin
                for (int i = RQ_DEPTH - 1; i >= 0; i--)
                    if (rq_addr[ch][i] == r.address) hit = i;
                if (hit >= 0) begin
                    p.status = ST_MERGED;
                    slot = hit;
                end else begin
                    for (int i = RQ_DEPTH - 1; i >= 0; i--)
                        if (rq_addr[ch][i] == '0) hit = i;
                    if (hit >= 0) begin
                        rq_addr[ch][hit] = r.address;
                        rd_cnt[ch] = rd_cnt[ch] + 1'b1;
                        p.status = ST_INSERTED;
                        slot = hit;
                    end
                end
            end else if (hit >= 0) begin
                // merged write keeps the data already stored
                p.status = ST_MERGED;
                slot = hit;
            end else begin
                for (int i = WQ_DEPTH - 1; i >= 0; i--)
                    if (wq_addr[ch][i] == '0) hit = i;
                if (hit >= 0) begin
                    wq_addr[ch][hit] = r.address;
                    wq_data[ch][hit] = r.write_data;
                    wr_cnt[ch] = wr_cnt[ch] + 1'b1;
                    p.status = ST_INSERTED;
                    slot = hit;
                end
            end
        end
        p.channel         = ch[0];
        p.slot_index      = slot[SLOT_W-1:0];
        p.route_to_nvm    = |r.address[ADDRESS_BITS-1 -: ROUTE_BITS];
        p.reply_to_icache = reply & r.is_instruction;
        p.reply_to_dcache = reply & r.is_data_access;
        p.reply_cpu       = (reply && (r.is_instruction || r.is_data_access)) ?
                            r.requester_cpu : '0;
        p.read_occupancy  = rd_cnt[ch];
        p.write_occupancy = wr_cnt[ch];
        return p;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    // request and result transfers, sampled on the rising edge
    always @(posedge i_clk) begin : monitor
        t_rsp want;
        if (!i_rst_n) begin
            req_taken = 1'b0;
        end else begin
            if (pop && !empty) begin
                rsp_count++;
                if (expected_rsp.size() == 0) begin
                    $error("result transfer with nothing outstanding");
                    err_count++;
                end else begin
                    want = expected_rsp.pop_front();
                    compare_field("status", want.status, o_rsp.status);
                    compare_field("channel", want.channel, o_rsp.channel);
                    compare_field("slot_index", want.slot_index, o_rsp.slot_index);
                    compare_field("route_to_nvm", want.route_to_nvm, o_rsp.route_to_nvm);
                    compare_field("reply_to_icache", want.reply_to_icache,
                                  o_rsp.reply_to_icache);
                    compare_field("reply_to_dcache", want.reply_to_dcache,
                                  o_rsp.reply_to_dcache);
                    compare_field("reply_cpu", want.reply_cpu, o_rsp.reply_cpu);
                    compare_field("reply_data", want.reply_data, o_rsp.reply_data);
                    compare_field("read_occupancy", want.read_occupancy,
                                  o_rsp.read_occupancy);
                    compare_field("write_occupancy", want.write_occupancy,
                                  o_rsp.write_occupancy);
                end
            end
            req_taken = push && !full;
            if (req_taken) begin
                expected_rsp.push_back(predict_request(i_req));
                accepted_cnt++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[memory_request_queue_with_forwarding_unit] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 15) begin
            burst_left = $urandom_range(30, 100);
            return 0;
        end
        if (r < 25)  return $urandom_range(20, 60);
        if (r < 120) return $urandom_range(4, 10);
        if (r < 450) return $urandom_range(1, 3);
        return 0;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (!push || req_taken) begin
            if (req_taken) gap_left = pick_gap();
            if (gap_left > 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
                push  <= 1'b1;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off so that the request side backs up
    always @(negedge i_clk) begin : pop_gen
        int r;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (!long_hold_done && rsp_count >= 400) begin
                long_hold_done = 1'b1;
                hold_cnt = LONG_HOLD;
                run_cnt = 0;
            end else if (hold_cnt == 0 && run_cnt == 0) begin
                r = $urandom_range(0, 999);
                if (r < 6)        hold_cnt = $urandom_range(20, 60);
                else if (r < 25)  run_cnt = $urandom_range(30, 100);
                else if (r < 320) hold_cnt = $urandom_range(1, 3);
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                pop <= 1'b0;
            end else begin
                if (run_cnt > 0) run_cnt--;
                pop <= 1'b1;
            end
        end
    end

    function automatic logic [ADDRESS_BITS-1:0] fresh_addr();
        logic [ADDRESS_BITS-1:0] a;
        a = ADDRESS_BITS'({$urandom, $urandom});
        if ($urandom_range(0, 1)) a[ADDRESS_BITS-1 -: ROUTE_BITS] = '0;
        if (a == '0) a = ADDRESS_BITS'(1);
        return a;
    endfunction

    task automatic add_req(input t_cmd cmd, input logic [ADDRESS_BITS-1:0] a,
                           input logic [DATA_W-1:0] d, input logic [CPU_W-1:0] cpu,
                           input logic from_i, input logic from_d);
        t_req r;
        r.command        = cmd;
        r.address        = a;
        r.write_data     = d;
        r.requester_cpu  = cpu;
        r.is_instruction = from_i;
        r.is_data_access = from_d;
        pending_reqs.push_back(r);
        queued_cnt++;
    endtask

    task automatic add_random_req();
        logic [ADDRESS_BITS-1:0] a;
        int r;
        r = $urandom_range(0, 99);
        // mostly reuse a small address set so merges and forwarding occur
        if (r == 0)      a = '0;
        else if (r < 76) a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else             a = fresh_addr();
        add_req($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, a, {$urandom, $urandom},
                CPU_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    endtask

    task automatic write_warmup(input logic v);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_WARMUP_DONE, 2'b00};
        pwdata  <= {{(CFG_DATA_W-1){1'b0}}, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        warm_model = v;
        #1;
    endtask

    task automatic settle();
        while (accepted_cnt != queued_cnt || expected_rsp.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        logic [ADDRESS_BITS-1:0] a_lo;
        logic [ADDRESS_BITS-1:0] b_hi;
        logic [ADDRESS_BITS-1:0] a_max;
        a_lo  = 40'h00_0000_0010;
        b_hi  = 40'hE0_0000_0021;
        a_max = {ADDRESS_BITS{1'b1}};
        for (int c = 0; c < CHANNELS; c++) begin
            rd_cnt[c] = '0;
            wr_cnt[c] = '0;
            for (int i = 0; i < RQ_DEPTH; i++) rq_addr[c][i] = '0;
            for (int i = 0; i < WQ_DEPTH; i++) begin
                wq_addr[c][i] = '0;
                wq_data[c][i] = '0;
            end
        end
        for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = fresh_addr();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // before warmup: every request bypasses, and only reads get a reply
        write_warmup(1'b0);
        add_req(CMD_READ,  40'h1, '0, 2'd0, 1'b1, 1'b0);
        add_req(CMD_READ,  a_max, {DATA_W{1'b1}}, 2'd3, 1'b0, 1'b1);
        add_req(CMD_READ,  '0, '0, 2'd2, 1'b1, 1'b1);
        add_req(CMD_READ,  b_hi, '0, 2'd1, 1'b0, 1'b0);
        add_req(CMD_WRITE, 40'h5, {DATA_W{1'b1}}, 2'd3, 1'b1, 1'b1);
        add_req(CMD_WRITE, '0, '0, 2'd0, 1'b0, 1'b0);
        repeat (150) add_random_req();
        settle();

        write_warmup(1'b1);
        add_req(CMD_WRITE, a_lo, 64'hDEAD_BEEF_0123_4567, 2'd0, 1'b0, 1'b1);
        add_req(CMD_READ,  a_lo, '0, 2'd1, 1'b1, 1'b0);
        add_req(CMD_WRITE, a_lo, {DATA_W{1'b1}}, 2'd2, 1'b0, 1'b0);
        add_req(CMD_READ,  a_lo, '0, 2'd3, 1'b0, 1'b1);
        add_req(CMD_READ,  b_hi, '0, 2'd2, 1'b1, 1'b1);
        add_req(CMD_READ,  b_hi, '0, 2'd1, 1'b0, 1'b1);
        add_req(CMD_WRITE, b_hi, '0, 2'd0, 1'b1, 1'b0);
        add_req(CMD_READ,  b_hi, {DATA_W{1'b1}}, 2'd3, 1'b1, 1'b1);
        add_req(CMD_READ,  '0, '0, 2'd1, 1'b1, 1'b1);
        add_req(CMD_WRITE, '0, {DATA_W{1'b1}}, 2'd2, 1'b1, 1'b1);
        add_req(CMD_WRITE, a_max, {DATA_W{1'b1}}, 2'd3, 1'b1, 1'b1);
        add_req(CMD_READ,  a_max, '0, 2'd3, 1'b1, 1'b1);
        add_req(CMD_READ,  40'h1, '0, 2'd0, 1'b0, 1'b0);
        add_req(CMD_READ,  40'h2, '0, 2'd1, 1'b1, 1'b0);
        repeat (800) add_random_req();
        settle();

        write_warmup(1'b0);
        repeat (100) add_random_req();
        settle();

        // queues stay as filled before: mostly merges, forwards and full drops now
        write_warmup(1'b1);
        repeat (780) add_random_req();
        settle();

        if (expected_rsp.size() != 0) begin
            $error("%0d results never arrived", expected_rsp.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("[memory_request_queue_with_forwarding_unit] OK");
        end else begin
            $display("[memory_request_queue_with_forwarding_unit] ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/mrqf_pkg.sv
rtl/mrqf_ram.sv
rtl/mrqf_fifo.sv
rtl/mrqf_front.sv
rtl/mrqf_back.sv
rtl/memory_request_queue_with_forwarding_unit.sv
rtl/mrqf_checker.sv
verif/tb.sv
